// ===== hdl/rycc_pkg.sv =====
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// No dependencies; imported by rycc_color_pipe, rgb_to_ycbcr420_converter and the testbench.
`default_nettype none

package rycc_pkg;

    // Width of the intermediate products and biased sums
    localparam int unsigned SUM_W = 16;

    // BT.601 studio-range coefficients (magnitudes; signs are applied in the sums)
    localparam logic [SUM_W-1:0] COEF_Y_R  = 16'd66;
    localparam logic [SUM_W-1:0] COEF_Y_G  = 16'd129;
    localparam logic [SUM_W-1:0] COEF_Y_B  = 16'd25;
    localparam logic [SUM_W-1:0] COEF_CB_R = 16'd38;
    localparam logic [SUM_W-1:0] COEF_CB_G = 16'd74;
    localparam logic [SUM_W-1:0] COEF_CB_B = 16'd112;
    localparam logic [SUM_W-1:0] COEF_CR_R = 16'd112;
    localparam logic [SUM_W-1:0] COEF_CR_G = 16'd94;
    localparam logic [SUM_W-1:0] COEF_CR_B = 16'd18;

    // Luma offset, and chroma offset pre-scaled by 256 so the high byte carries it
    localparam logic [7:0]       LUMA_OFFSET   = 8'd16;
    localparam logic [SUM_W-1:0] CHROMA_BIAS   = 16'd32768;

    // Input transaction
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
    } pixel_in_t;

    // Result transaction
    typedef struct packed {
        logic [7:0]  luma;
        logic [7:0]  chroma_blue;
        logic [7:0]  chroma_red;
        logic        chroma_valid;
        logic [10:0] chroma_column;
        logic [10:0] chroma_row;
    } pixel_out_t;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } rycc_adv_t;

endpackage

`default_nettype wire

// ===== hdl/rycc_color_pipe.sv =====
// Three-stage color matrix: products, biased sums, byte extraction.
// Depends on rycc_pkg; stage enables come from the top-level flow control.
`default_nettype none

module rycc_color_pipe
    import rycc_pkg::*;
(
    input  wire logic       aclk,
    input  wire rycc_adv_t  adv,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic [7:0]      luma,
    output logic [7:0]      chroma_blue,
    output logic [7:0]      chroma_red
);

    logic [SUM_W-1:0] y_r_reg,  y_g_reg,  y_b_reg;
    logic [SUM_W-1:0] cb_r_reg, cb_g_reg, cb_b_reg;
    logic [SUM_W-1:0] cr_r_reg, cr_g_reg, cr_b_reg;
    logic [SUM_W-1:0] y_r_next,  y_g_next,  y_b_next;
    logic [SUM_W-1:0] cb_r_next, cb_g_next, cb_b_next;
    logic [SUM_W-1:0] cr_r_next, cr_g_next, cr_b_next;

    logic [SUM_W-1:0] y_sum_reg,  cb_sum_reg,  cr_sum_reg;
    logic [SUM_W-1:0] y_sum_next, cb_sum_next, cr_sum_next;

    logic [7:0] luma_reg, cb_reg, cr_reg;
    logic [7:0] luma_next, cb_next, cr_next;

    // Stage 1: constant-coefficient products
    always_comb begin
        y_r_next  = SUM_W'(red)   * COEF_Y_R;
        y_g_next  = SUM_W'(green) * COEF_Y_G;
        y_b_next  = SUM_W'(blue)  * COEF_Y_B;
        cb_r_next = SUM_W'(red)   * COEF_CB_R;
        cb_g_next = SUM_W'(green) * COEF_CB_G;
        cb_b_next = SUM_W'(blue)  * COEF_CB_B;
        cr_r_next = SUM_W'(red)   * COEF_CR_R;
        cr_g_next = SUM_W'(green) * COEF_CR_G;
        cr_b_next = SUM_W'(blue)  * COEF_CR_B;
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            y_r_reg  <= y_r_next;
            y_g_reg  <= y_g_next;
            y_b_reg  <= y_b_next;
            cb_r_reg <= cb_r_next;
            cb_g_reg <= cb_g_next;
            cb_b_reg <= cb_b_next;
            cr_r_reg <= cr_r_next;
            cr_g_reg <= cr_g_next;
            cr_b_reg <= cr_b_next;
        end
    end

    // Stage 2: sums; chroma biased by 128*256 so the result never goes negative
    always_comb begin
        y_sum_next  = y_r_reg + y_g_reg + y_b_reg;
        cb_sum_next = CHROMA_BIAS + cb_b_reg - cb_r_reg - cb_g_reg;
        cr_sum_next = CHROMA_BIAS + cr_r_reg - cr_g_reg - cr_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            y_sum_reg  <= y_sum_next;
            cb_sum_reg <= cb_sum_next;
            cr_sum_reg <= cr_sum_next;
        end
    end

    // Stage 3: take the high byte (floor divide by 256) and add the luma offset
    always_comb begin
        luma_next = y_sum_reg[SUM_W-1 -: 8] + LUMA_OFFSET;
        cb_next   = cb_sum_reg[SUM_W-1 -: 8];
        cr_next   = cr_sum_reg[SUM_W-1 -: 8];
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            luma_reg <= luma_next;
            cb_reg   <= cb_next;
            cr_reg   <= cr_next;
        end
    end

    assign luma        = luma_reg;
    assign chroma_blue = cb_reg;
    assign chroma_red  = cr_reg;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_ycbcr420_converter.sv =====
// BT.601 studio-range RGB to YCbCr 4:2:0 converter, one result per pixel.
// Accepts one pixel per clock while s_ready is high and delivers its result from the
// registered output of the three-stage color matrix (products, sums, byte extraction),
// and with m_ready held high the throughput is one pixel every cycle. Each stage
// holds while the stage after it is full and stalled, so s_ready falls only when
// all three stages are occupied. Chroma fields are valid for pixels at an even
// column and an even row inside MAX_DIMENSION and are zero otherwise.
// Depends on rycc_pkg and rycc_color_pipe.
`default_nettype none

module rgb_to_ycbcr420_converter
    import rycc_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire pixel_in_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pixel_out_t     m_data
);

    localparam logic [16:0] FRAME_LIMIT = 17'(MAX_DIMENSION);

    rycc_adv_t adv;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;

    logic        cv1_reg, cv2_reg, cv3_reg;
    logic        cv1_next;
    logic [10:0] col1_reg, col2_reg, col3_reg;
    logic [10:0] row1_reg, row2_reg, row3_reg;
    logic [10:0] col1_next, row1_next;

    logic [7:0] luma_w, cb_w, cr_w;

    // Load a stage when it is empty or its contents move on this cycle
    always_comb begin
        adv.s3 = m_ready || !v3_reg;
        adv.s2 = adv.s3 || !v2_reg;
        adv.s1 = adv.s2 || !v1_reg;
    end

    assign s_ready = adv.s1;

    // Advance the valid bits
    always_comb begin
        v1_next = adv.s1 ? s_valid : v1_reg;
        v2_next = adv.s2 ? v1_reg  : v2_reg;
        v3_next = adv.s3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Chroma site: both coordinates even and inside the frame
    always_comb begin
        cv1_next  = ({5'd0, s_data.pixel_column} < FRAME_LIMIT)
                 && ({5'd0, s_data.pixel_row} < FRAME_LIMIT)
                 && !s_data.pixel_column[0] && !s_data.pixel_row[0];
        col1_next = s_data.pixel_column[11:1];
        row1_next = s_data.pixel_row[11:1];
    end

    // Carry the position alongside the color matrix
    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            cv1_reg  <= cv1_next;
            col1_reg <= col1_next;
            row1_reg <= row1_next;
        end
        if (adv.s2) begin
            cv2_reg  <= cv1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
        end
        if (adv.s3) begin
            cv3_reg  <= cv2_reg;
            col3_reg <= col2_reg;
            row3_reg <= row2_reg;
        end
    end

    rycc_color_pipe u_color (
        .aclk        (aclk),
        .adv         (adv),
        .red         (s_data.red),
        .green       (s_data.green),
        .blue        (s_data.blue),
        .luma        (luma_w),
        .chroma_blue (cb_w),
        .chroma_red  (cr_w)
    );

    // Drop chroma fields for pixels that are not chroma sites
    always_comb begin
        m_data.luma          = luma_w;
        m_data.chroma_blue   = cv3_reg ? cb_w     : 8'd0;
        m_data.chroma_red    = cv3_reg ? cr_w     : 8'd0;
        m_data.chroma_valid  = cv3_reg;
        m_data.chroma_column = cv3_reg ? col3_reg : 11'd0;
        m_data.chroma_row    = cv3_reg ? row3_reg : 11'd0;
    end

    assign m_valid = v3_reg;

`ifndef SYNTH
    // Pipeline not full must leave room for a new transaction
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg || !v2_reg || !v3_reg) |-> s_ready)
        else $error("s_ready low with a free pipeline stage");

    // Luma stays within the studio range
    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.luma >= 8'd16 && m_data.luma <= 8'd235))
        else $error("luma out of studio range");

    // Chroma stays within the studio range on chroma sites
    a_chroma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.chroma_valid) |->
            (m_data.chroma_blue >= 8'd16 && m_data.chroma_blue <= 8'd239 &&
             m_data.chroma_red >= 8'd16 && m_data.chroma_red <= 8'd239))
        else $error("chroma out of studio range");

    // An odd-column pixel never enters stage 1 as a chroma site
    a_odd_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.pixel_column[0]) |=> (v1_reg && !cv1_reg))
        else $error("odd column tagged as chroma site");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_rgb_to_ycbcr420_converter.sv =====
// Self-checking testbench for rgb_to_ycbcr420_converter: directed and random pixels in, BT.601 results checked.
// Depends on rycc_pkg and the converter RTL; uses a scoreboard class with its own color predictor.
`timescale 1ns / 1ps

module tb_rgb_to_ycbcr420_converter;
    import rycc_pkg::*;

    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int          RANDOM_PIXELS = 1900;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 8;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    pixel_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    pixel_out_t m_data;

    // Compute expected BT.601 results and compare them in order
    class pixel_scoreboard;
        pixel_out_t pending[$];
        int         failures;

        function new();
            failures = 0;
        endfunction

        function pixel_out_t convert_bt601(pixel_in_t p);
            int         r;
            int         g;
            int         b;
            int         y_sum;
            int         cb_sum;
            int         cr_sum;
            pixel_out_t o;
            r = int'(p.red);
            g = int'(p.green);
            b = int'(p.blue);
            o = '0;
            y_sum = 66 * r + 129 * g + 25 * b;
            o.luma = 8'((y_sum >>> 8) + 16);
            // Chroma only for even column and even row inside the frame
            if (p.pixel_column < MAX_DIMENSION && p.pixel_row < MAX_DIMENSION &&
                !p.pixel_column[0] && !p.pixel_row[0]) begin
                cb_sum = 112 * b - 38 * r - 74 * g;
                cr_sum = 112 * r - 94 * g - 18 * b;
                o.chroma_blue   = 8'((cb_sum >>> 8) + 128);
                o.chroma_red    = 8'((cr_sum >>> 8) + 128);
                o.chroma_valid  = 1'b1;
                o.chroma_column = p.pixel_column[11:1];
                o.chroma_row    = p.pixel_row[11:1];
            end
            return o;
        endfunction

        function void note_pixel(pixel_in_t p);
            pending.push_back(convert_bt601(p));
        endfunction

        function void flag(string field, int exp_val, int act_val);
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch on %s: expected %0d, got %0d",
                         $realtime, field, exp_val, act_val);
        endfunction

        function void check_result(pixel_out_t got);
            pixel_out_t exp_out;
            if (pending.size() == 0) begin
                flag("unexpected transaction", 0, 1);
                return;
            end
            exp_out = pending.pop_front();
            if (got.luma !== exp_out.luma)
                flag("luma", exp_out.luma, got.luma);
            if (got.chroma_blue !== exp_out.chroma_blue)
                flag("chroma_blue", exp_out.chroma_blue, got.chroma_blue);
            if (got.chroma_red !== exp_out.chroma_red)
                flag("chroma_red", exp_out.chroma_red, got.chroma_red);
            if (got.chroma_valid !== exp_out.chroma_valid)
                flag("chroma_valid", exp_out.chroma_valid, got.chroma_valid);
            if (got.chroma_column !== exp_out.chroma_column)
                flag("chroma_column", exp_out.chroma_column, got.chroma_column);
            if (got.chroma_row !== exp_out.chroma_row)
                flag("chroma_row", exp_out.chroma_row, got.chroma_row);
        endfunction
    endclass

    pixel_scoreboard sb;
    logic            gaps_on;

    rgb_to_ycbcr420_converter #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short idle stretches, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic logic [7:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'd0;
        else if (roll == 1)
            return 8'd255;
        else
            return 8'($urandom);
    endfunction

    // Hold valid and payload until the transaction is accepted
    task automatic send_pixel(input pixel_in_t p, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_fields(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                               input logic [11:0] col, input logic [11:0] row);
        pixel_in_t p;
        p.blue         = b;
        p.green        = g;
        p.red          = r;
        p.pixel_column = col;
        p.pixel_row    = row;
        send_pixel(p, 0);
    endtask

    // Note accepted inputs and check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && s_ready)
                sb.note_pixel(s_data);
        end
    end

    // Stall the result channel in random runs
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                // Long stretch with no stalls
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end
            m_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge aclk);
        end
    end

    // Main stimulus
    initial begin
        pixel_in_t p;
        int        waited;
        int        gap;
        sb      = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        gaps_on = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: color extremes, primaries, coordinate parity and range edges
        send_fields(8'd0,   8'd0,   8'd0,   12'd0,    12'd0);
        send_fields(8'd255, 8'd255, 8'd255, 12'd0,    12'd0);
        send_fields(8'd0,   8'd0,   8'd255, 12'd2,    12'd0);
        send_fields(8'd0,   8'd255, 8'd0,   12'd4,    12'd0);
        send_fields(8'd255, 8'd0,   8'd0,   12'd6,    12'd0);
        send_fields(8'd255, 8'd255, 8'd0,   12'd0,    12'd2);
        send_fields(8'd0,   8'd255, 8'd255, 12'd0,    12'd4);
        send_fields(8'd255, 8'd0,   8'd255, 12'd0,    12'd6);
        send_fields(8'd128, 8'd128, 8'd128, 12'd1,    12'd0);
        send_fields(8'd200, 8'd50,  8'd10,  12'd0,    12'd1);
        send_fields(8'd10,  8'd50,  8'd200, 12'd1,    12'd1);
        send_fields(8'd255, 8'd255, 8'd255, 12'd4094, 12'd4094);
        send_fields(8'd0,   8'd0,   8'd0,   12'd4095, 12'd4094);
        send_fields(8'd1,   8'd2,   8'd3,   12'd4094, 12'd4095);
        send_fields(8'd255, 8'd0,   8'd255, 12'd4095, 12'd4095);
        send_fields(8'd0,   8'd255, 8'd0,   12'd2730, 12'd1364);
        send_fields(8'd127, 8'd128, 8'd129, 12'd1365, 12'd2731);

        // Random pixels, in blocks with and without source gaps chosen at random
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 100 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            p.blue  = pick_channel();
            p.green = pick_channel();
            p.red   = pick_channel();
            if ($urandom_range(0, 3) == 0) begin
                // Small raster region, dense on even and odd positions
                p.pixel_column = 12'($urandom_range(0, 7));
                p.pixel_row    = 12'($urandom_range(0, 7));
            end else begin
                p.pixel_column = 12'($urandom);
                p.pixel_row    = 12'($urandom);
            end
            gap = gaps_on ? pick_gap() : 0;
            send_pixel(p, gap);
        end
        s_valid <= 1'b0;
        // Let the monitor note the last transaction before counting what is left
        @(posedge aclk);

        // Drain outstanding results
        waited = 0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending.size() != 0) begin
            $display("Verification failed");
        end else begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            if (sb.failures == 0 && sb.pending.size() == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rycc_pkg.sv
hdl/rycc_color_pipe.sv
hdl/rgb_to_ycbcr420_converter.sv
sim/tb_rgb_to_ycbcr420_converter.sv
